// File: hdl/acfp_pkg.sv
package acfp_pkg;

  // Line and word geometry
  localparam int unsigned MAX_WORD_BITS = 16;
  localparam int unsigned WB_W          = 5;
  localparam int unsigned BP_W          = 4;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned STEP_W        = 4;

  // Sequencer steps: start bit, eight data bits, stop bit, then pad
  localparam logic [STEP_W-1:0] STEP_START = 4'd0;
  localparam logic [STEP_W-1:0] STEP_STOP  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_PAD   = 4'd10;

  localparam logic [WB_W-1:0] WORD_BITS_RESET = 5'd16;

  // Function codes carried on the input tuser
  localparam logic FUNC_SEND  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  // One classified command from the front end
  typedef struct packed {
    logic              flush;
    logic              restart;
    logic              pad;
    logic [CHAR_W-1:0] char_byte;
  } acfp_cmd_t;

  // Top bit position for a raw word width, clamped to 1..MAX_WORD_BITS
  function automatic logic [BP_W-1:0] eff_wm1(input logic [WB_W-1:0] wb);
    logic [BP_W-1:0] r;
    if (wb == '0) begin
      r = '0;
    end else if (wb > WB_W'(MAX_WORD_BITS)) begin
      r = BP_W'(MAX_WORD_BITS - 1);
    end else begin
      r = BP_W'(wb - 5'd1);
    end
    return r;
  endfunction

  // Ones in bit positions p down to 0
  function automatic logic [MAX_WORD_BITS-1:0] low_mask(input logic [BP_W-1:0] p);
    logic [MAX_WORD_BITS:0] t;
    t = ((MAX_WORD_BITS+1)'(1) << ({1'b0, p} + 5'd1)) - (MAX_WORD_BITS+1)'(1);
    return t[MAX_WORD_BITS-1:0];
  endfunction

endpackage

// File: hdl/acfp_front.sv
module acfp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] char_byte
  input  logic                  in_tlast,   // queue_empty
  input  logic                  in_tuser,   // func
  input  logic                  q_full,
  output logic                  q_push,
  output acfp_pkg::acfp_cmd_t   q_din
);
  import acfp_pkg::*;

  logic bs_r;
  logic bs_nxt;

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // Classify the item: mode comes from the stream state and queue_empty
  always_comb begin
    q_din.flush     = (in_tuser == FUNC_FLUSH);
    q_din.restart   = bs_r;
    q_din.pad       = in_tlast;
    q_din.char_byte = in_tdata[CHAR_W-1:0];
  end

  // Track between-streams; flush leaves it alone
  always_comb begin
    bs_nxt = bs_r;
    if (q_push && (in_tuser == FUNC_SEND)) begin
      bs_nxt = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= 1'b1;
    end else begin
      bs_r <= bs_nxt;
    end
  end

endmodule

// File: hdl/acfp_queue.sv
module acfp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  acfp_pkg::acfp_cmd_t din,
  output logic                full,
  input  logic                pop,
  output logic                valid,
  output acfp_pkg::acfp_cmd_t dout
);
  import acfp_pkg::*;

  acfp_cmd_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign dout  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the command
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: hdl/acfp_back.sv
module acfp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  acfp_pkg::acfp_cmd_t cmd,
  output logic                cmd_pop,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wm1,
  input  logic [3:0]          wm1,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  output logic                out_tlast
);
  import acfp_pkg::*;

  logic [MAX_WORD_BITS-1:0] partial_r;
  logic [BP_W-1:0]          bp_r, bp_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [MAX_WORD_BITS-1:0] out_word_r;
  logic                     out_last_r;

  logic [STEP_W-1:0]        step_c;
  logic [STEP_W-1:0]        rem_c;
  logic [BP_W-1:0]          bp_cur;
  logic                     bit_c;
  logic [MAX_WORD_BITS-1:0] word_c;
  logic                     emit_c;
  logic                     last_c;
  logic                     done_c;
  logic                     adv_c;

  // Current step: a flush goes straight to the pad step
  always_comb begin
    step_c = cmd.flush ? STEP_PAD : step_r;
    bp_cur = ((step_c == STEP_START) && cmd.restart) ? wm1 : bp_r;
    rem_c  = STEP_STOP - step_c;
  end

  // Pick the line bit for this step
  always_comb begin
    if (step_c == STEP_START) begin
      bit_c = 1'b0;
    end else if (step_c == STEP_STOP) begin
      bit_c = 1'b1;
    end else begin
      bit_c = cmd.char_byte[3'(step_c - 4'd1)];
    end
  end

  // Place one bit, or pad the partial word with mark bits
  always_comb begin
    word_c = partial_r;
    if (step_c == STEP_PAD) begin
      word_c = partial_r | low_mask(bp_cur);
      emit_c = (bp_cur != wm1);
      last_c = 1'b1;
      bp_nxt = wm1;
      done_c = 1'b1;
    end else begin
      word_c[bp_cur] = bit_c;
      emit_c = (bp_cur == '0);
      last_c = (rem_c <= wm1) && !(cmd.pad && (rem_c != '0));
      bp_nxt = emit_c ? wm1 : bp_cur - 4'd1;
      done_c = (step_c == STEP_STOP) && !cmd.pad;
    end
  end

  // Advance unless a word is due and the output slot is held
  always_comb begin
    adv_c         = cmd_valid && (!emit_c || !out_valid_r || out_tready);
    cmd_pop       = adv_c && done_c;
    step_nxt      = done_c ? STEP_START : step_c + 4'd1;
    out_valid_nxt = out_valid_r;
    if (adv_c && emit_c) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r        <= BP_W'(MAX_WORD_BITS - 1);
      step_r      <= STEP_START;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        bp_r   <= cfg_wm1;
        step_r <= STEP_START;
      end else if (adv_c) begin
        bp_r   <= bp_nxt;
        step_r <= step_nxt;
      end
    end
  end

  // Hold the partial word and the output word
  always_ff @(posedge clk) begin
    if (adv_c) begin
      partial_r <= word_c;
    end
    if (adv_c && emit_c) begin
      out_word_r <= word_c | ~low_mask(wm1);
      out_last_r <= last_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;

endmodule

// File: hdl/async_char_framer_packer_core.sv
// Channel | Ports                        | Content
// in      | in_tvalid/in_tready          | tdata[7:0] char_byte, tlast queue_empty,
//         |                              | tuser func (0 send, 1 flush)
// out     | out_tvalid/out_tready        | tdata[15:0] tx_word, tlast last
// cfg     | cfg_valid/cfg_ready          | cfg_data[4:0] word_bits
//
// The back end shifts one line bit per cycle; a send steps through start, data
// and stop bits, and a pad step if queue_empty asks; a flush has just the pad step.
// Words leave through a one-entry output register; the back end stalls only when
// a word is due and that register is still held.
// A two-entry command queue lets the input side run ahead of the back end.
// Reset (rst_n low, synchronous) restores word_bits 16 and empties everything.
module async_char_framer_packer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_byte
  input  logic        in_tlast,    // queue_empty
  input  logic        in_tuser,    // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] tx_word
  output logic        out_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data     // [4:0] word_bits
);
  import acfp_pkg::*;

  logic [WB_W-1:0] word_bits_r;
  logic [WB_W-1:0] word_bits_nxt;
  logic            cfg_we;
  logic [BP_W-1:0] wm1;
  logic [BP_W-1:0] cfg_wm1;

  acfp_cmd_t q_din;
  acfp_cmd_t q_dout;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_valid;

  // Width register
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign wm1       = eff_wm1(word_bits_r);
  assign cfg_wm1   = eff_wm1(cfg_data);

  always_comb begin
    word_bits_nxt = cfg_we ? cfg_data : word_bits_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_bits_r <= WORD_BITS_RESET;
    end else begin
      word_bits_r <= word_bits_nxt;
    end
  end

  acfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  acfp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  acfp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd        (q_dout),
    .cmd_pop    (q_pop),
    .cfg_we     (cfg_we),
    .cfg_wm1    (cfg_wm1),
    .wm1        (wm1),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: hdl/acfp_checker.sv
module acfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [4:0]  cfg_data
);
  import acfp_pkg::*;

  logic [WB_W-1:0]          chk_wb_r;
  logic [MAX_WORD_BITS-1:0] width_mask_c;

  // Shadow the width register from the config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_wb_r <= WORD_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      chk_wb_r <= cfg_data;
    end
  end

  assign width_mask_c = low_mask(eff_wm1(chk_wb_r));

  // Reset empties the output and opens the input
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output valid or input stalled after reset");

  // A stalled input transfer holds its contents
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast)
      && $stable(in_tuser))
    else $error("input item changed while stalled");

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // Positions above the word width read as mark bits
  a_upper_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata | width_mask_c) == 16'hffff))
    else $error("bits above word width are not ones");

endmodule

bind async_char_framer_packer_core acfp_checker u_acfp_checker (.*);

// File: test/async_char_framer_packer_core_tb.sv
`timescale 1ns / 1ps

module async_char_framer_packer_core_tb;
  import acfp_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;

  // One command on the input stream, and one transmit word on the output stream
  typedef struct packed {
    logic       func;
    logic [7:0] ch;
    logic       qe;
  } char_cmd_t;

  typedef struct packed {
    logic [15:0] tx_word;
    logic        last;
  } tx_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] char_byte
  logic        in_tlast   = 1'b0; // queue_empty
  logic        in_tuser   = 1'b0; // func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] tx_word
  logic        out_tlast;         // last
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data   = '0;   // [4:0] word_bits

  async_char_framer_packer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  char_cmd_t  char_cmds[$];
  tx_result_t exp_words[$];
  tx_result_t burst[$];

  int error_count = 0;
  int in_accepted = 0;
  bit no_idle     = 1'b0;

  // Framer state as the block should hold it
  logic [4:0]  wb_reg    = WORD_BITS_RESET;
  logic [15:0] part_word = '1;
  logic [3:0]  next_pos  = 4'd15;
  logic        between   = 1'b1;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Top bit position for the current width, out-of-range widths clamped
  function automatic logic [3:0] top_pos();
    if (wb_reg == 5'd0) return 4'd0;
    if (wb_reg > 5'(MAX_WORD_BITS)) return 4'(MAX_WORD_BITS - 1);
    return 4'(wb_reg - 5'd1);
  endfunction

  // Emit the word; positions at or above the width read as mark bits
  function automatic void emit_word();
    logic [16:0] used;
    tx_result_t  r;
    used = (17'd1 << (top_pos() + 5'd1)) - 17'd1;
    r.tx_word = part_word | ~used[15:0];
    r.last = 1'b0;
    burst.push_back(r);
  endfunction

  function automatic void pack_bit(input logic b);
    part_word[next_pos] = b;
    if (next_pos == 4'd0) begin
      emit_word();
      next_pos = top_pos();
    end else begin
      next_pos = next_pos - 4'd1;
    end
  endfunction

  // Fill the rest of a partial word with mark bits; nothing when no bits wait
  function automatic void pad_word();
    logic [16:0] low;
    if (next_pos != top_pos()) begin
      low = (17'd1 << ({1'b0, next_pos} + 5'd1)) - 17'd1;
      part_word = part_word | low[15:0];
      emit_word();
      next_pos = top_pos();
    end
  endfunction

  // Work out the words one accepted command produces
  function automatic void frame_cmd(input char_cmd_t c);
    tx_result_t r;
    burst = {};
    if (c.func == FUNC_FLUSH) begin
      pad_word();
    end else begin
      if (between) next_pos = top_pos();
      between = c.qe;
      pack_bit(1'b0);
      for (int i = 0; i < 8; i++) pack_bit(c.ch[i]);
      pack_bit(1'b1);
      if (c.qe) pad_word();
    end
    if (burst.size() > 0) begin
      r = burst.pop_back();
      r.last = 1'b1;
      burst.push_back(r);
    end
    foreach (burst[i]) exp_words.push_back(burst[i]);
  endfunction

  function automatic void queue_cmd(input logic f, input logic [7:0] c, input logic q);
    char_cmd_t cmd;
    cmd.func = f;
    cmd.ch = c;
    cmd.qe = q;
    char_cmds.push_back(cmd);
  endfunction

  // Mostly well-formed streams of random bytes, some flushes and loose commands
  task automatic gen_traffic(input int n);
    int cnt;
    int len;
    int r;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 10) begin
        queue_cmd(FUNC_FLUSH, 8'($urandom), 1'($urandom));
        cnt++;
      end else if (r < 22) begin
        queue_cmd(FUNC_SEND, 8'($urandom), 1'($urandom));
        cnt++;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          queue_cmd(FUNC_SEND, 8'($urandom), i == len - 1);
          cnt++;
          if ($urandom_range(99) < 6) begin
            queue_cmd(FUNC_FLUSH, 8'($urandom), 1'($urandom));
            cnt++;
          end
        end
      end
    end
  endtask

  // Wait until every command is taken and every word has come out
  task automatic wait_idle();
    do @(posedge clk); while (char_cmds.size() != 0 || in_tvalid || exp_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_word_bits(input logic [4:0] wb);
    @(posedge clk);
    cfg_data  <= wb;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    wb_reg   = wb;
    next_pos = top_pos();
  endtask

  // Drive commands from the pending queue; hold each until it transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        frame_cmd(char_cmds.pop_front());
        in_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (char_cmds.size() > 0 && (no_idle || $urandom_range(99) >= 22)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= char_cmds[0].ch;
          in_tlast  <= char_cmds[0].qe;
          in_tuser  <= char_cmds[0].func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each word transfer; stall the output at random, once for a long stretch
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    tx_result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (exp_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h last %b", out_tdata, out_tlast));
        end else begin
          e = exp_words.pop_front();
          if (out_tdata !== e.tx_word)
            report_mismatch($sformatf("tx_word %h, expected %h", out_tdata, e.tx_word));
          if (out_tlast !== e.last)
            report_mismatch($sformatf("last %b, expected %b on word %h",
                                      out_tlast, e.last, e.tx_word));
        end
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (!hold_done && in_accepted >= 160 && char_cmds.size() > 8) begin
        hold_done  <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_idle || $urandom_range(99) >= 22;
      end
    end
  end

  // End the run when no transfer of any kind happens for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d words still expected",
               quiet_cycles, exp_words.size());
      $display("async_char_framer_packer_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset width: flush with nothing waiting, singles, a full stream, flushes
    queue_cmd(FUNC_FLUSH, 8'hff, 1'b1);
    queue_cmd(FUNC_SEND,  8'h00, 1'b1);
    queue_cmd(FUNC_SEND,  8'hff, 1'b1);
    queue_cmd(FUNC_SEND,  8'ha5, 1'b0);
    queue_cmd(FUNC_SEND,  8'h5a, 1'b0);
    queue_cmd(FUNC_FLUSH, 8'h3c, 1'b0);
    queue_cmd(FUNC_SEND,  8'h81, 1'b0);
    queue_cmd(FUNC_SEND,  8'h7e, 1'b1);
    queue_cmd(FUNC_FLUSH, 8'h00, 1'b0);
    wait_idle();

    // One bit per word: ten words per character
    write_word_bits(5'd1);
    queue_cmd(FUNC_SEND,  8'hc3, 1'b1);
    queue_cmd(FUNC_SEND,  8'h01, 1'b0);
    queue_cmd(FUNC_SEND,  8'h80, 1'b1);
    queue_cmd(FUNC_FLUSH, 8'hff, 1'b1);
    wait_idle();

    // Zero width acts as one; widths above the limit act as the limit
    write_word_bits(5'd0);
    queue_cmd(FUNC_SEND,  8'h55, 1'b1);
    queue_cmd(FUNC_SEND,  8'haa, 1'b0);
    queue_cmd(FUNC_FLUSH, 8'h00, 1'b1);
    wait_idle();
    write_word_bits(5'd31);
    queue_cmd(FUNC_SEND,  8'h0f, 1'b0);
    queue_cmd(FUNC_SEND,  8'hf0, 1'b0);
    queue_cmd(FUNC_FLUSH, 8'h99, 1'b0);
    queue_cmd(FUNC_SEND,  8'h66, 1'b1);
    wait_idle();

    // Random traffic over a spread of widths
    write_word_bits(5'd16);
    gen_traffic(30);
    wait_idle();
    write_word_bits(5'd3);
    gen_traffic(25);
    wait_idle();
    write_word_bits(5'd1);
    gen_traffic(20);
    wait_idle();
    write_word_bits(5'd9);
    no_idle = 1'b1;
    gen_traffic(30);
    wait_idle();
    no_idle = 1'b0;
    write_word_bits(5'd10);
    gen_traffic(50);
    wait_idle();
    write_word_bits(5'($urandom_range(1, 16)));
    gen_traffic(25);
    wait_idle();
    write_word_bits(5'd0);
    gen_traffic(15);
    wait_idle();
    write_word_bits(5'($urandom_range(17, 31)));
    gen_traffic(20);
    wait_idle();
    write_word_bits(5'd31);
    gen_traffic(20);
    wait_idle();

    if (exp_words.size() != 0)
      report_mismatch($sformatf("%0d words never came out", exp_words.size()));
    if (error_count == 0) begin
      $display("async_char_framer_packer_core test passed");
    end else begin
      $display("async_char_framer_packer_core test failed");
    end
    $finish;
  end

endmodule
